[hdl/smd_pkg.sv]
// types, constants and helpers shared by the sha-1 digest unit
`default_nettype none

package smd_pkg;

  // block and round geometry
  localparam int unsigned BLK_WORDS  = 16;
  localparam int unsigned NUM_ROUNDS = 80;
  localparam int unsigned CNT_W      = 61;
  localparam int unsigned LEN_W      = 64;
  localparam int unsigned FILL_W     = 6;
  localparam int unsigned RND_W      = 7;

  localparam logic [RND_W-1:0]  RND_LAST = RND_W'(NUM_ROUNDS - 1);
  localparam logic [RND_W-1:0]  RND_P1   = RND_W'(20);
  localparam logic [RND_W-1:0]  RND_P2   = RND_W'(40);
  localparam logic [RND_W-1:0]  RND_P3   = RND_W'(60);
  localparam logic [FILL_W-1:0] LEN_POS  = FILL_W'(56);
  localparam logic [7:0]        PAD_MARK = 8'h80;

  // round constants
  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  // initial chaining words
  localparam logic [31:0] H_INIT0 = 32'h67452301;
  localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
  localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
  localparam logic [31:0] H_INIT3 = 32'h10325476;
  localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

  // input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } smd_in_t;

  // result word
  typedef struct packed {
    logic [31:0] digest_h0;
    logic [31:0] digest_h1;
    logic [31:0] digest_h2;
    logic [31:0] digest_h3;
    logic [31:0] digest_h4;
  } smd_out_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_DONE
  } smd_state_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic       shift_en;
    logic [7:0] shift_byte;
    logic       start;
    logic       round_en;
    logic       fold;
    logic       reinit;
  } smd_ctl_t;

  // rotate left helpers
  function automatic logic [31:0] rotl1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    return {x[1:0], x[31:2]};
  endfunction

endpackage

`default_nettype wire

[hdl/smd_sched.sv]
// block buffer and message schedule window
`default_nettype none

module smd_sched (
  input  wire logic            clk,
  input  wire smd_pkg::smd_ctl_t ctl,
  output logic [31:0]          w_cur
);
  import smd_pkg::*;

  logic [31:0] w_r   [BLK_WORDS];
  logic [31:0] w_nxt [BLK_WORDS];
  logic [31:0] w_new;

  // next schedule word from the window taps
  assign w_new = rotl1(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0]);
  assign w_cur = w_r[0];

  // bytes shift in big-endian, rounds shift whole words
  always_comb begin
    for (int i = 0; i < BLK_WORDS; i++) begin
      w_nxt[i] = w_r[i];
    end
    if (ctl.shift_en) begin
      for (int i = 0; i < BLK_WORDS - 1; i++) begin
        w_nxt[i] = {w_r[i][23:0], w_r[i+1][31:24]};
      end
      w_nxt[BLK_WORDS-1] = {w_r[BLK_WORDS-1][23:0], ctl.shift_byte};
    end else if (ctl.round_en) begin
      for (int i = 0; i < BLK_WORDS - 1; i++) begin
        w_nxt[i] = w_r[i+1];
      end
      w_nxt[BLK_WORDS-1] = w_new;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BLK_WORDS; i++) begin
      w_r[i] <= w_nxt[i];
    end
  end

endmodule

`default_nettype wire

[hdl/smd_core.sv]
// shared round unit with working and chaining registers
`default_nettype none

module smd_core (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire smd_pkg::smd_ctl_t       ctl,
  input  wire logic [smd_pkg::RND_W-1:0] rnd,
  input  wire logic [31:0]             w_cur,
  output smd_pkg::smd_out_t            digest
);
  import smd_pkg::*;

  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0] h0_r, h1_r, h2_r, h3_r, h4_r;
  logic [31:0] h0_nxt, h1_nxt, h2_nxt, h3_nxt, h4_nxt;
  logic [31:0] f_val, k_val, t_val;

  // round function and constant by round group
  always_comb begin
    if (rnd < RND_P1) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K_0;
    end else if (rnd < RND_P2) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_1;
    end else if (rnd < RND_P3) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K_2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_3;
    end
  end

  assign t_val = rotl5(a_r) + f_val + e_r + k_val + w_cur;

  // working registers: load from chaining words, then one round per cycle
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    e_nxt = e_r;
    if (ctl.start) begin
      a_nxt = h0_r;
      b_nxt = h1_r;
      c_nxt = h2_r;
      d_nxt = h3_r;
      e_nxt = h4_r;
    end else if (ctl.round_en) begin
      a_nxt = t_val;
      b_nxt = a_r;
      c_nxt = rotl30(b_r);
      d_nxt = c_r;
      e_nxt = d_r;
    end
  end

  // chaining words: fold after the last round, restart after a digest
  always_comb begin
    h0_nxt = h0_r;
    h1_nxt = h1_r;
    h2_nxt = h2_r;
    h3_nxt = h3_r;
    h4_nxt = h4_r;
    if (ctl.reinit) begin
      h0_nxt = H_INIT0;
      h1_nxt = H_INIT1;
      h2_nxt = H_INIT2;
      h3_nxt = H_INIT3;
      h4_nxt = H_INIT4;
    end else if (ctl.fold) begin
      h0_nxt = h0_r + a_r;
      h1_nxt = h1_r + b_r;
      h2_nxt = h2_r + c_r;
      h3_nxt = h3_r + d_r;
      h4_nxt = h4_r + e_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    e_r <= e_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h0_r <= H_INIT0;
      h1_r <= H_INIT1;
      h2_r <= H_INIT2;
      h3_r <= H_INIT3;
      h4_r <= H_INIT4;
    end else begin
      h0_r <= h0_nxt;
      h1_r <= h1_nxt;
      h2_r <= h2_nxt;
      h3_r <= h3_nxt;
      h4_r <= h4_nxt;
    end
  end

  assign digest = '{digest_h0: h0_r, digest_h1: h1_r, digest_h2: h2_r,
                    digest_h3: h3_r, digest_h4: h4_r};

endmodule

`default_nettype wire

[hdl/sha1_message_digest_unit.sv]
// sha-1 digest unit top level: sequencer, padding, counters and result register
//
//   channel | ports                            | word
//   --------+----------------------------------+----------------------------------
//   input   | in_valid  in_ready  in_data      | one message byte and/or end mark
//   result  | out_valid out_ready out_data     | five 32-bit digest words
//
// a byte that does not complete a block is shifted in and leaves in_ready high.
// a byte that completes a block starts 80 rounds and one fold, all through the
// single round unit; in_ready is low meanwhile.
// the end word adds the pad bytes one by one (up to 64 per padded block), a
// compression per padded block and a final move of the digest out.
// the digest register holds the result until taken; a new message is accepted
// while it waits, and a second digest stalls until the first is taken.
// rst_n is synchronous, active low; the unit is ready right after reset.
`default_nettype none

module sha1_message_digest_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire smd_pkg::smd_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output smd_pkg::smd_out_t      out_data
);
  import smd_pkg::*;

  smd_state_t        state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic              pad_r, pad_nxt;
  logic              first_r, first_nxt;
  logic              lenok_r, lenok_nxt;
  logic              final_r, final_nxt;
  logic              out_valid_r, out_valid_nxt;
  smd_out_t          out_data_r;
  smd_out_t          digest;
  smd_ctl_t          ctl;
  logic [31:0]       w_cur;
  logic              in_acc, byte_acc, eom_acc;
  logic              pad_shift, block_full, len_byte, out_load;
  logic [7:0]        pad_byte;

  // handshake decode
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign byte_acc  = in_acc & in_data.byte_present;
  assign eom_acc   = in_acc & in_data.end_of_message;
  assign pad_shift = (state_r == ST_PAD);
  assign block_full = (byte_acc | pad_shift) & (&fill_r);
  assign len_byte  = ~first_r & lenok_r & (fill_r >= LEN_POS);
  assign out_load  = (state_r == ST_DONE) & (~out_valid_r | out_ready);
  assign cnt_inc   = cnt_r + CNT_W'(1);

  // padding byte: marker, zeros, then big-endian bit length
  always_comb begin
    if (first_r) begin
      pad_byte = PAD_MARK;
    end else if (len_byte) begin
      pad_byte = len_r[LEN_W-1 -: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (block_full) begin
          state_nxt = ST_ROUND;
        end else if (eom_acc) begin
          state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (block_full) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (final_r) begin
          state_nxt = ST_DONE;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl.shift_en   = 1'b0;
    ctl.shift_byte = in_data.data_byte;
    ctl.start      = block_full;
    ctl.round_en   = 1'b0;
    ctl.fold       = 1'b0;
    ctl.reinit     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        ctl.shift_en = byte_acc;
      end
      ST_PAD: begin
        ctl.shift_en   = 1'b1;
        ctl.shift_byte = pad_byte;
      end
      ST_ROUND: ctl.round_en = 1'b1;
      ST_FOLD:  ctl.fold = 1'b1;
      ST_DONE:  ctl.reinit = out_load;
      default:  ctl.round_en = 1'b0;
    endcase
  end

  // counters and padding flags
  always_comb begin
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    rnd_nxt       = rnd_r;
    pad_nxt       = pad_r;
    first_nxt     = first_r;
    lenok_nxt     = lenok_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r & ~out_ready;

    if (ctl.shift_en) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
    if (byte_acc) begin
      cnt_nxt = cnt_inc;
    end
    // latch the bit length of the finished message
    if (eom_acc) begin
      pad_nxt   = 1'b1;
      first_nxt = 1'b1;
      lenok_nxt = 1'b0;
      final_nxt = 1'b0;
      len_nxt   = {(in_data.byte_present ? cnt_inc : cnt_r), 3'b000};
    end
    // padding progress: length goes in once the marker sits before byte 56
    if (pad_shift) begin
      first_nxt = 1'b0;
      if (len_byte) begin
        len_nxt = {len_r[LEN_W-9:0], 8'h00};
      end
      if (&fill_r) begin
        final_nxt = lenok_r & ~first_r;
        lenok_nxt = 1'b1;
      end else if (first_r) begin
        lenok_nxt = (fill_r < LEN_POS);
      end
    end
    // round counter
    if (ctl.start) begin
      rnd_nxt = '0;
    end else if (ctl.round_en) begin
      rnd_nxt = rnd_r + RND_W'(1);
    end
    // digest out and restart of the message state
    if (out_load) begin
      out_valid_nxt = 1'b1;
      cnt_nxt       = '0;
      pad_nxt       = 1'b0;
      final_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      cnt_r       <= '0;
      rnd_r       <= '0;
      pad_r       <= 1'b0;
      first_r     <= 1'b0;
      lenok_r     <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      rnd_r       <= rnd_nxt;
      pad_r       <= pad_nxt;
      first_r     <= first_nxt;
      lenok_r     <= lenok_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    if (out_load) begin
      out_data_r <= digest;
    end
  end

  smd_sched u_sched (
    .clk   (clk),
    .ctl   (ctl),
    .w_cur (w_cur)
  );

  smd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .rnd    (rnd_r),
    .w_cur  (w_cur),
    .digest (digest)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a compression always starts on a freshly completed block
  a_round_on_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && $past(state_r) != ST_ROUND) |-> (fill_r == '0 && rnd_r == '0))
    else $error("compression started on a partial block");

  // the last padded block must carry the length field
  a_final_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    final_r |-> (pad_r && lenok_r && !first_r))
    else $error("final block flagged before length placement");

  // a digest is only produced right after a fold
  a_done_after_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && $past(state_r) != ST_DONE) |-> $past(state_r) == ST_FOLD)
    else $error("digest state entered without a fold");

  // round counter never runs past the last round
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (rnd_r <= RND_LAST))
    else $error("round counter overrun");

endmodule

`default_nettype wire

[tb/tb_sha1_message_digest_unit.sv]
// sha-1 digest unit bench: directed and random messages checked against a local sha-1 model
module tb_sha1_message_digest_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import smd_pkg::*;

  // sha-1 initial words, round constants and pad marker for the model
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;
  localparam logic [31:0] RK0 = 32'h5A827999;
  localparam logic [31:0] RK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RK3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam int ITEM_TARGET = 1450;
  localparam int HOLD_CYC    = 1500;
  localparam int TAIL_CYC    = 300;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  smd_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  smd_out_t out_data;

  sha1_message_digest_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // words waiting to be driven and digests waiting to be seen
  smd_in_t  word_q [$];
  smd_out_t digest_q [$];

  // model state
  logic [31:0] hash_w [5];
  logic [7:0]  blk_buf [64];
  logic [60:0] msg_bytes;

  // shared bench state
  bit    in_took;
  bit    out_took;
  bit    idle_on;
  bit    hold_ask;
  bit    hold_ack;
  int    send_gap;
  int    recv_gap;
  int    hold_left;
  int    words_queued;
  int    fail_cnt;
  int    boundary_len [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
  string field_name [5] = '{"digest_h0", "digest_h1", "digest_h2", "digest_h3", "digest_h4"};

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic int draw_gap();
    return idle_on ? int'($urandom_range(0, 6)) : 0;
  endfunction

  // back to the initial chaining words
  task automatic restart_digest();
    hash_w = '{IV0, IV1, IV2, IV3, IV4};
    for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;
    msg_bytes = '0;
  endtask

  // one 80-round compression of blk_buf into hash_w
  task automatic sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = hash_w[0]; b = hash_w[1]; c = hash_w[2]; d = hash_w[3]; e = hash_w[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = RK0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = RK1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = RK2;
      end else begin
        f = b ^ c ^ d; k = RK3;
      end
      t = rol32(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol32(b, 30); b = a; a = t;
    end
    hash_w[0] += a; hash_w[1] += b; hash_w[2] += c; hash_w[3] += d; hash_w[4] += e;
  endtask

  // absorb one accepted word; an end mark pads and queues the digest
  task automatic predict_digest(input smd_in_t wd);
    logic [63:0] bit_len;
    smd_out_t    dg;
    int          pos;
    if (wd.byte_present) begin
      blk_buf[msg_bytes[5:0]] = wd.data_byte;
      msg_bytes = msg_bytes + 61'd1;
      if (msg_bytes[5:0] == 6'd0) sha1_compress();
    end
    if (wd.end_of_message) begin
      bit_len = {msg_bytes, 3'b000};
      pos = int'(msg_bytes[5:0]);
      blk_buf[pos] = PAD_BYTE;
      pos++;
      // no room for the length field: pad out and compress an extra block
      if (pos > 56) begin
        while (pos < 64) begin
          blk_buf[pos] = 8'h00;
          pos++;
        end
        sha1_compress();
        pos = 0;
      end
      while (pos < 56) begin
        blk_buf[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++) blk_buf[56+i] = bit_len[(7-i)*8 +: 8];
      sha1_compress();
      dg.digest_h0 = hash_w[0];
      dg.digest_h1 = hash_w[1];
      dg.digest_h2 = hash_w[2];
      dg.digest_h3 = hash_w[3];
      dg.digest_h4 = hash_w[4];
      digest_q = {digest_q, dg};
      restart_digest();
    end
  endtask

  task automatic offer_word(input logic [7:0] val, input bit present, input bit eom);
    smd_in_t wd;
    wd.data_byte      = val;
    wd.byte_present   = present;
    wd.end_of_message = eom;
    word_q = {word_q, wd};
    words_queued++;
  endtask

  // random message; the end mark rides on the last byte or comes alone
  task automatic queue_message(input int len, input bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) offer_word(8'($urandom), 1'b0, 1'b0);
      offer_word(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!(end_on_byte && len > 0)) offer_word(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int pick_len();
    int r;
    r = int'($urandom_range(0, 9));
    if (r < 6) return int'($urandom_range(0, 12));
    if (r < 9) return boundary_len[$urandom_range(0, 9)];
    return int'($urandom_range(0, 150));
  endfunction

  // sender stops until every word is taken and every digest has come
  task automatic wait_drain();
    @(posedge clk);
    while (word_q.size() != 0 || in_valid || digest_q.size() != 0) @(posedge clk);
  endtask

  // handshake sampling, prediction and digest check
  always @(posedge clk) begin
    smd_out_t    want;
    logic [31:0] want_w [5];
    logic [31:0] got_w [5];
    in_took  <= rst_n && in_valid && in_ready;
    out_took <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready) predict_digest(in_data);
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest word %h", out_data);
        fail_cnt++;
      end else begin
        want   = digest_q.pop_front();
        want_w = '{want.digest_h0, want.digest_h1, want.digest_h2, want.digest_h3,
                   want.digest_h4};
        got_w  = '{out_data.digest_h0, out_data.digest_h1, out_data.digest_h2,
                   out_data.digest_h3, out_data.digest_h4};
        for (int i = 0; i < 5; i++) begin
          if (got_w[i] !== want_w[i]) begin
            $error("%s expected %h actual %h", field_name[i], want_w[i], got_w[i]);
            fail_cnt++;
          end
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the word until taken
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (word_q.size() > 0) begin
      in_data  <= word_q.pop_front();
      in_valid <= 1'b1;
      send_gap = draw_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result ready with per-word stalls and an occasional long hold
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_ask != hold_ack) begin
        hold_ack  = hold_ask;
        hold_left = HOLD_CYC;
      end
      if (out_took) recv_gap = draw_gap();
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus sequence
  initial begin
    restart_digest();
    idle_on = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty message
    offer_word(8'h00, 1'b0, 1'b1);
    // "abc" with the end mark on the last byte
    offer_word(8'h61, 1'b1, 1'b0);
    offer_word(8'h62, 1'b1, 1'b0);
    offer_word(8'h63, 1'b1, 1'b1);
    // ignored word, then one-byte message ending on the byte
    offer_word(8'h5A, 1'b0, 1'b0);
    offer_word(8'hFF, 1'b1, 1'b1);
    // one zero byte, end on its own word with junk data
    offer_word(8'h00, 1'b1, 1'b0);
    offer_word(8'hFF, 1'b0, 1'b1);
    // bytes with ignored words mixed in
    offer_word(8'h00, 1'b0, 1'b0);
    offer_word(8'hAA, 1'b1, 1'b0);
    offer_word(8'hFF, 1'b0, 1'b0);
    offer_word(8'h55, 1'b1, 1'b0);
    offer_word(8'h3C, 1'b0, 1'b1);
    wait_drain();

    // random with idling on both sides
    while (words_queued < 600) queue_message(pick_len(), 1'($urandom));
    wait_drain();

    // back to back, no idling
    idle_on = 1'b0;
    while (words_queued < 1000) queue_message(pick_len(), 1'($urandom));
    wait_drain();

    // long receiver hold while short messages keep coming
    hold_ask = ~hold_ask;
    for (int i = 0; i < 40; i++) queue_message(int'($urandom_range(0, 3)), 1'($urandom));
    wait_drain();

    idle_on = 1'b1;
    while (words_queued < ITEM_TARGET) queue_message(pick_len(), 1'($urandom));
    wait_drain();

    repeat (TAIL_CYC) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("sha1_message_digest_unit: match");
    end else begin
      $display("sha1_message_digest_unit: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("sha1_message_digest_unit: mismatch");
    $finish;
  end

endmodule

[sim.f]
hdl/smd_pkg.sv
hdl/smd_sched.sv
hdl/smd_core.sv
hdl/sha1_message_digest_unit.sv
tb/tb_sha1_message_digest_unit.sv
